// File: hdl/mf3_pkg.sv
package mf3_pkg;

  localparam int unsigned CH_W         = 8;
  localparam int unsigned WIN_DIM      = 3;
  localparam int unsigned WIN_TAPS     = WIN_DIM * WIN_DIM;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned WIDTH_REG_W  = 11;
  localparam int unsigned HEIGHT_REG_W = 13;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned WIDTH_RESET  = 640;
  localparam int unsigned HEIGHT_RESET = 480;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  localparam int unsigned PIX_W = $bits(pixel_t);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic col_load;
    logic med_load;
  } med_en_t;

  typedef logic [WIN_DIM-1:0][CH_W-1:0] trio_t;

  function automatic trio_t sort3(input logic [CH_W-1:0] a, input logic [CH_W-1:0] b,
                                  input logic [CH_W-1:0] c);
    logic [CH_W-1:0] x;
    logic [CH_W-1:0] y;
    logic [CH_W-1:0] z;
    logic [CH_W-1:0] t;
    x = a;
    y = b;
    z = c;
    if (x > y) begin
      t = x; x = y; y = t;
    end
    if (y > z) begin
      t = y; y = z; z = t;
    end
    if (x > y) begin
      t = x; x = y; y = t;
    end
    return {z, y, x};
  endfunction

  function automatic logic [CH_W-1:0] med3(input logic [CH_W-1:0] a,
                                           input logic [CH_W-1:0] b,
                                           input logic [CH_W-1:0] c);
    logic [CH_W-1:0] lo;
    logic [CH_W-1:0] hi;
    logic [CH_W-1:0] m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

endpackage

// File: hdl/mf3_median.sv
module mf3_median (
  input  logic                                          clk_i,
  input  mf3_pkg::med_en_t                              en_i,
  input  logic [mf3_pkg::WIN_TAPS-1:0][mf3_pkg::CH_W-1:0] px_i,
  output logic [mf3_pkg::CH_W-1:0]                      med_o
);

  mf3_pkg::trio_t [mf3_pkg::WIN_DIM-1:0] col_q;
  logic [mf3_pkg::CH_W-1:0]              med_q;
  logic [mf3_pkg::CH_W-1:0]              lo_max;
  logic [mf3_pkg::CH_W-1:0]              mid_med;
  logic [mf3_pkg::CH_W-1:0]              hi_min;
  mf3_pkg::trio_t                        lo_s;
  mf3_pkg::trio_t                        hi_s;

  always_ff @(posedge clk_i) begin
    if (en_i.col_load) begin
      for (int c = 0; c < mf3_pkg::WIN_DIM; c++) begin
        col_q[c] <= mf3_pkg::sort3(px_i[c], px_i[mf3_pkg::WIN_DIM + c],
                                   px_i[2 * mf3_pkg::WIN_DIM + c]);
      end
    end
  end

  always_comb begin
    lo_s    = mf3_pkg::sort3(col_q[0][0], col_q[1][0], col_q[2][0]);
    hi_s    = mf3_pkg::sort3(col_q[0][2], col_q[1][2], col_q[2][2]);
    lo_max  = lo_s[2];
    hi_min  = hi_s[0];
    mid_med = mf3_pkg::med3(col_q[0][1], col_q[1][1], col_q[2][1]);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.med_load) begin
      med_q <= mf3_pkg::med3(lo_max, mid_med, hi_min);
    end
  end

  assign med_o = med_q;

endmodule

// File: hdl/median_filter_3x3_rgb_unit.sv
// 3x3 median filter over an RGB raster stream.
// Input channel: in_valid_i / in_stall_o with pixel_red_i, pixel_green_i,
// pixel_blue_i, one beat per pixel in raster order. Output channel:
// out_valid_o / out_stall_i with the three channel medians plus line_end_o
// and frame_end_o. Border pixels and frames narrower or shorter than three
// give no output beat.
// Frame size is set through cfg_we_i / cfg_idx_i / cfg_wdata_i; the user
// must write it only while the block is idle, which the block does not
// enforce. Any valid write restarts the frame at the next pixel.
// Throughput: one pixel per cycle while the receiver does not stall, set
// by one read and one write of the shared two-line memory per pixel.
// Reset clears the counters, the window and all valid bits and loads a
// 640 x 480 frame size; line memory contents are not cleared.
// When the receiver stalls, the result holds and the pipeline keeps taking
// pixels until its empty stages are filled, then in_stall_o rises.
module median_filter_3x3_rgb_unit #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [mf3_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [mf3_pkg::CH_W-1:0]          pixel_red_i,
  input  logic [mf3_pkg::CH_W-1:0]          pixel_green_i,
  input  logic [mf3_pkg::CH_W-1:0]          pixel_blue_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [mf3_pkg::CH_W-1:0]          median_red_o,
  output logic [mf3_pkg::CH_W-1:0]          median_green_o,
  output logic [mf3_pkg::CH_W-1:0]          median_blue_o,
  output logic                              line_end_o,
  output logic                              frame_end_o
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned PW    = mf3_pkg::PIX_W;
  localparam logic [WW-1:0] WIDTH_INIT = WW'((mf3_pkg::WIDTH_RESET > MAX_WIDTH) ?
                                             MAX_WIDTH : mf3_pkg::WIDTH_RESET);
  localparam logic [HW-1:0] HEIGHT_INIT = HW'((mf3_pkg::HEIGHT_RESET > MAX_HEIGHT) ?
                                              MAX_HEIGHT : mf3_pkg::HEIGHT_RESET);

  logic [WW-1:0]    width_q, width_d;
  logic [HW-1:0]    height_q, height_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             cfg_hit;
  logic [mf3_pkg::WIDTH_REG_W-1:0]  cfg_w;
  logic [mf3_pkg::HEIGHT_REG_W-1:0] cfg_h;

  logic             accept;
  logic             last_col, last_row, has_res, le, fe;
  mf3_pkg::pixel_t  cur;

  logic [2*PW-1:0]  line_mem [MAX_WIDTH];
  logic [2*PW-1:0]  rd_q;
  logic [2*PW-1:0]  fwd_data_q;
  logic             fwd_q;
  logic [2*PW-1:0]  entry;
  logic [2*PW-1:0]  wr_data;

  logic             s1_v_q, s1_res_q, s1_le_q, s1_fe_q;
  mf3_pkg::pixel_t  s1_pix_q;
  logic [COL_W-1:0] s1_col_q;

  mf3_pkg::pixel_t [mf3_pkg::WIN_TAPS-1:0] win_q, win_d;
  mf3_pkg::pixel_t [mf3_pkg::WIN_TAPS-1:0] s2_win_q;
  logic             s2_v_q, s2_le_q, s2_fe_q;
  logic             s3_v_q, s3_le_q, s3_fe_q;
  logic             out_v_q, out_le_q, out_fe_q;

  logic             out_ready, s3_move, s3_can, s2_move, s2_can, s1_move, s1_can;
  mf3_pkg::med_en_t med_en;

  logic [mf3_pkg::WIN_TAPS-1:0][mf3_pkg::CH_W-1:0] px_r, px_g, px_b;

  // handshake
  assign out_ready  = !out_v_q || !out_stall_i;
  assign s3_move    = s3_v_q && out_ready;
  assign s3_can     = !s3_v_q || s3_move;
  assign s2_move    = s2_v_q && s3_can;
  assign s2_can     = !s2_v_q || s2_move;
  assign s1_move    = s1_v_q && (s2_can || !s1_res_q);
  assign s1_can     = !s1_v_q || s1_move;
  assign in_stall_o = !s1_can;
  assign accept     = in_valid_i && s1_can;

  // configuration
  assign cfg_w = cfg_wdata_i[mf3_pkg::WIDTH_REG_W-1:0];
  assign cfg_h = cfg_wdata_i[mf3_pkg::HEIGHT_REG_W-1:0];

  always_comb begin
    width_d  = width_q;
    height_d = height_q;
    cfg_hit  = 1'b0;
    if (cfg_we_i) begin
      case (mf3_pkg::cfg_idx_e'(cfg_idx_i))
        mf3_pkg::CFG_FRAME_WIDTH: begin
          cfg_hit = 1'b1;
          width_d = (32'(cfg_w) > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_w);
        end
        mf3_pkg::CFG_FRAME_HEIGHT: begin
          cfg_hit  = 1'b1;
          height_d = (32'(cfg_h) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_h);
        end
        default: begin
          cfg_hit = 1'b0;
        end
      endcase
    end
  end

  // position
  assign cur      = '{red: pixel_red_i, green: pixel_green_i, blue: pixel_blue_i};
  assign last_col = (32'(col_q) + 32'd1) >= 32'(width_q);
  assign last_row = (32'(row_q) + 32'd1) >= 32'(height_q);
  assign has_res  = (32'(width_q) >= mf3_pkg::WIN_DIM) && (32'(height_q) >= mf3_pkg::WIN_DIM)
                 && (32'(col_q) >= mf3_pkg::WIN_DIM - 1) && (32'(row_q) >= mf3_pkg::WIN_DIM - 1);
  assign le       = (32'(col_q) + 32'd1) == 32'(width_q);
  assign fe       = le && ((32'(row_q) + 32'd1) == 32'(height_q));

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_hit) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : ROW_W'(32'(row_q) + 32'd1);
      end else begin
        col_d = COL_W'(32'(col_q) + 32'd1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_INIT;
      height_q <= HEIGHT_INIT;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      col_q    <= col_d;
      row_q    <= row_d;
    end
  end

  // line memory: upper line in the high half, middle line in the low half
  assign entry   = fwd_q ? fwd_data_q : rd_q;
  assign wr_data = {entry[PW-1:0], s1_pix_q};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= line_mem[col_q];
    end
    if (s1_move) begin
      line_mem[s1_col_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (accept) begin
      fwd_q <= s1_move && (s1_col_q == col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      fwd_data_q <= wr_data;
      s1_pix_q   <= cur;
      s1_col_q   <= col_q;
      s1_res_q   <= has_res;
      s1_le_q    <= le;
      s1_fe_q    <= fe;
    end
  end

  // window shift
  always_comb begin
    for (int r = 0; r < mf3_pkg::WIN_DIM; r++) begin
      win_d[r * mf3_pkg::WIN_DIM]     = win_q[r * mf3_pkg::WIN_DIM + 1];
      win_d[r * mf3_pkg::WIN_DIM + 1] = win_q[r * mf3_pkg::WIN_DIM + 2];
    end
    win_d[2]                    = entry[2*PW-1:PW];
    win_d[mf3_pkg::WIN_DIM + 2] = entry[PW-1:0];
    win_d[mf3_pkg::WIN_TAPS-1]  = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (s1_move) begin
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move && s1_res_q) begin
      s2_win_q <= win_d;
      s2_le_q  <= s1_le_q;
      s2_fe_q  <= s1_fe_q;
    end
    if (s2_move) begin
      s3_le_q <= s2_le_q;
      s3_fe_q <= s2_fe_q;
    end
    if (s3_move) begin
      out_le_q <= s3_le_q;
      out_fe_q <= s3_fe_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_can) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_can) begin
        s2_v_q <= s1_move && s1_res_q;
      end
      if (s3_can) begin
        s3_v_q <= s2_move;
      end
      if (out_ready) begin
        out_v_q <= s3_move;
      end
    end
  end

  // median network
  assign med_en.col_load = s2_move;
  assign med_en.med_load = s3_move;

  for (genvar i = 0; i < mf3_pkg::WIN_TAPS; i++) begin : g_tap
    assign px_r[i] = s2_win_q[i].red;
    assign px_g[i] = s2_win_q[i].green;
    assign px_b[i] = s2_win_q[i].blue;
  end

  mf3_median u_med_red (
    .clk_i (clk_i),
    .en_i  (med_en),
    .px_i  (px_r),
    .med_o (median_red_o)
  );

  mf3_median u_med_green (
    .clk_i (clk_i),
    .en_i  (med_en),
    .px_i  (px_g),
    .med_o (median_green_o)
  );

  mf3_median u_med_blue (
    .clk_i (clk_i),
    .en_i  (med_en),
    .px_i  (px_b),
    .med_o (median_blue_o)
  );

  assign out_valid_o = out_v_q;
  assign line_end_o  = out_le_q;
  assign frame_end_o = out_fe_q;

endmodule

// File: hdl/mf3_checker.sv
module mf3_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           cfg_we_i,
  input logic [mf3_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [mf3_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic [mf3_pkg::CH_W-1:0]       pixel_red_i,
  input logic [mf3_pkg::CH_W-1:0]       pixel_green_i,
  input logic [mf3_pkg::CH_W-1:0]       pixel_blue_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [mf3_pkg::CH_W-1:0]       median_red_o,
  input logic [mf3_pkg::CH_W-1:0]       median_green_o,
  input logic [mf3_pkg::CH_W-1:0]       median_blue_o,
  input logic                           line_end_o,
  input logic                           frame_end_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(median_red_o) && $stable(median_green_o)
      && $stable(median_blue_o) && $stable(line_end_o) && $stable(frame_end_o))
    else $error("stalled output beat changed");

  a_frame_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> line_end_o)
    else $error("frame end without line end");

  a_no_stall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

endmodule

bind median_filter_3x3_rgb_unit mf3_checker u_mf3_checker (.*);
